FILE: rtl/core/trsmc_pkg.sv
// types, constants and arithmetic helpers shared by the matrix composer
`default_nettype none
package trsmc_pkg;

  typedef struct packed {
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
    logic signed [31:0] angle_x;
    logic signed [31:0] angle_y;
    logic signed [31:0] angle_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] col0;
    logic signed [31:0] col1;
    logic signed [31:0] col2;
    logic signed [31:0] col3;
    logic [1:0]         row_index;
    logic               last_row;
  } out_item_t;

  // translation and scales, delayed alongside the angle math
  typedef struct packed {
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
  } side_t;

  typedef struct packed {
    logic signed [31:0] s;
    logic signed [31:0] c;
  } sc_t;

  // rotation elements, row-major, Q2.30 with one guard bit
  typedef logic [8:0][32:0] mat_t;

  localparam int TRIG_LAT = 17;
  localparam int MAT_LAT  = 3;
  localparam int SIDE_LAT = TRIG_LAT + MAT_LAT;

  localparam logic [1:0]  ROW_LAST = 2'd3;
  localparam logic [31:0] PI_Q30   = 32'd3373259426;
  localparam logic [30:0] ONE_Q30  = 31'h4000_0000;

  // reciprocals for exact floor division of 31-bit values by small constants
  localparam int SH_72 = 31 + $clog2(72);
  localparam int SH_42 = 31 + $clog2(42);
  localparam int SH_20 = 31 + $clog2(20);
  localparam int SH_6  = 31 + $clog2(6);
  localparam int SH_56 = 31 + $clog2(56);
  localparam int SH_30 = 31 + $clog2(30);
  localparam int SH_12 = 31 + $clog2(12);
  localparam logic [31:0] RCP_72 = 32'(((64'd1 << SH_72) + 64'd71) / 64'd72);
  localparam logic [31:0] RCP_42 = 32'(((64'd1 << SH_42) + 64'd41) / 64'd42);
  localparam logic [31:0] RCP_20 = 32'(((64'd1 << SH_20) + 64'd19) / 64'd20);
  localparam logic [31:0] RCP_6  = 32'(((64'd1 << SH_6) + 64'd5) / 64'd6);
  localparam logic [31:0] RCP_56 = 32'(((64'd1 << SH_56) + 64'd55) / 64'd56);
  localparam logic [31:0] RCP_30 = 32'(((64'd1 << SH_30) + 64'd29) / 64'd30);
  localparam logic [31:0] RCP_12 = 32'(((64'd1 << SH_12) + 64'd11) / 64'd12);

  // unsigned q2.30 product, round half up
  function automatic logic [30:0] umul30(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] p;
    p = 62'(a) * 62'(b) + (62'd1 << 29);
    return p[60:30];
  endfunction

  // floor(n / d) through the matching reciprocal and shift
  function automatic logic [30:0] divc(input logic [30:0] n, input logic [31:0] m,
                                       input int sh);
    logic [62:0] p;
    p = 63'(n) * 63'(m);
    return 31'(p >> sh);
  endfunction

  // signed q2.30 product, round half up
  function automatic logic signed [31:0] smul30(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd536870912;
    return p[61:30];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/trsmc_trig.sv
// pipelined sine and cosine of three angles in degrees
`default_nettype none
module trsmc_trig import trsmc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    adv,
  input  wire logic                    in_vld,
  input  wire logic [2:0][31:0]        angles,
  output logic                         out_vld,
  output sc_t [2:0]                    trig
);

  localparam int    UW       = 35;
  localparam int    N        = UW - FRAC_BITS;
  localparam int    K_RED    = N + 6;
  localparam int    QW       = N - 5;
  localparam int    RW       = FRAC_BITS + 6;
  localparam int    YPW      = RW + 32;
  localparam longint FULL    = 64'sd360 << FRAC_BITS;
  localparam longint KF      = ((64'sd2147483648 + FULL - 64'sd1) / FULL) * FULL;
  localparam logic [N:0]    M_RED  = (N+1)'(((64'd1 << K_RED) + 64'd44) / 64'd45);
  localparam logic [RW-1:0] EIGHTH = RW'(45) << FRAC_BITS;
  localparam logic [36:0]   MX     = 37'(((64'd1 << 42) + 64'd44) / 64'd45);

  logic [TRIG_LAT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[TRIG_LAT-2:0], in_vld};
    end
  end

  assign out_vld = vld_r[TRIG_LAT-1];

  for (genvar g = 0; g < 3; g++) begin : g_lane
    logic [UW-1:0]    u_r;
    logic [2*N:0]     red_prod_r;
    logic [RW-1:0]    ul1_r, ul2_r;
    logic [QW-1:0]    q_r;
    logic [RW-1:0]    rem_r;
    logic [37:0]      y_r;
    logic [54:0]      pa_r, pb_r;
    logic [2:0]       oct_r [3:15];
    logic [30:0]      x_r [6:14];
    logic [30:0]      x2_r [7:12];
    logic [30:0]      sv_r [8:15];
    logic [30:0]      cv_r [8:15];
    sc_t              sc_r;

    logic [UW-1:0]    u_nxt;
    logic [RW-1:0]    rem_raw, rem_nxt;
    logic [YPW-1:0]   yp;
    logic [73:0]      xsum;
    logic signed [31:0] s0, c0;
    sc_t              sc_nxt;

    always_comb begin
      u_nxt   = UW'($signed(angles[g])) + UW'(KF);
      rem_raw = ul2_r - RW'(RW'(q_r) * EIGHTH);
      // odd octants count the angle back from the octant end
      rem_nxt = q_r[0] ? (EIGHTH - rem_raw) : rem_raw;
      yp      = YPW'(rem_r) * YPW'(PI_Q30) + (YPW'(90) << FRAC_BITS);
      xsum    = (74'(pa_r) << 18) + 74'(pb_r);
      s0      = 32'(sv_r[15]);
      c0      = 32'(cv_r[15]);
      unique case (oct_r[15])
        3'd0: begin sc_nxt.s = s0;  sc_nxt.c = c0;  end
        3'd1: begin sc_nxt.s = c0;  sc_nxt.c = s0;  end
        3'd2: begin sc_nxt.s = c0;  sc_nxt.c = -s0; end
        3'd3: begin sc_nxt.s = s0;  sc_nxt.c = -c0; end
        3'd4: begin sc_nxt.s = -s0; sc_nxt.c = -c0; end
        3'd5: begin sc_nxt.s = -c0; sc_nxt.c = -s0; end
        3'd6: begin sc_nxt.s = -c0; sc_nxt.c = s0;  end
        default: begin sc_nxt.s = -s0; sc_nxt.c = c0; end
      endcase
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        u_r        <= u_nxt;
        red_prod_r <= (2*N+1)'(u_r[UW-1:FRAC_BITS]) * (2*N+1)'(M_RED);
        ul1_r      <= u_r[RW-1:0];
        q_r        <= QW'(red_prod_r >> K_RED);
        ul2_r      <= ul1_r;
        rem_r      <= rem_nxt;
        oct_r[3]   <= q_r[2:0];
        for (int i = 4; i <= 15; i++) oct_r[i] <= oct_r[i-1];
        y_r        <= 38'(yp >> FRAC_BITS);
        pa_r       <= 55'(y_r[37:20]) * 55'(MX);
        pb_r       <= 55'(y_r[19:2]) * 55'(MX);
        x_r[6]     <= 31'(xsum >> 42);
        for (int i = 7; i <= 14; i++) x_r[i] <= x_r[i-1];
        x2_r[7]    <= umul30(x_r[6], x_r[6]);
        for (int i = 8; i <= 12; i++) x2_r[i] <= x2_r[i-1];
        // horner chains for sine (sv) and cosine (cv)
        sv_r[8]    <= divc(x2_r[7], RCP_72, SH_72);
        cv_r[8]    <= divc(x2_r[7], RCP_56, SH_56);
        sv_r[9]    <= umul30(x2_r[8], ONE_Q30 - sv_r[8]);
        cv_r[9]    <= umul30(x2_r[8], ONE_Q30 - cv_r[8]);
        sv_r[10]   <= divc(sv_r[9], RCP_42, SH_42);
        cv_r[10]   <= divc(cv_r[9], RCP_30, SH_30);
        sv_r[11]   <= umul30(x2_r[10], ONE_Q30 - sv_r[10]);
        cv_r[11]   <= umul30(x2_r[10], ONE_Q30 - cv_r[10]);
        sv_r[12]   <= divc(sv_r[11], RCP_20, SH_20);
        cv_r[12]   <= divc(cv_r[11], RCP_12, SH_12);
        sv_r[13]   <= umul30(x2_r[12], ONE_Q30 - sv_r[12]);
        cv_r[13]   <= umul30(x2_r[12], ONE_Q30 - cv_r[12]);
        sv_r[14]   <= divc(sv_r[13], RCP_6, SH_6);
        cv_r[14]   <= ONE_Q30 - (cv_r[13] >> 1);
        sv_r[15]   <= umul30(x_r[14], ONE_Q30 - sv_r[14]);
        cv_r[15]   <= cv_r[14];
        sc_r       <= sc_nxt;
      end
    end

    assign trig[g] = sc_r;
  end

endmodule
`default_nettype wire

FILE: rtl/core/trsmc_mat.sv
// three-stage product tree forming the rotation matrix
`default_nettype none
module trsmc_mat import trsmc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      adv,
  input  wire logic      in_vld,
  input  wire sc_t [2:0] trig,
  output logic           out_vld,
  output mat_t           mat
);

  logic [MAT_LAT-1:0] vld_r;
  logic signed [31:0] cycz_r, cysz_r, sxsy_r, cxsz_r, cxcz_r;
  logic signed [31:0] sxcy_r, cxsy_r, sxsz_r, sxcz_r, cxcy_r, sy_r, sz_r, cz_r;
  logic signed [31:0] a_r, b_r, c_r, d_r;
  logic signed [31:0] cycz1_r, cysz1_r, cxsz1_r, cxcz1_r, sxcy1_r;
  logic signed [31:0] sxsz1_r, sxcz1_r, cxcy1_r, sy1_r;
  mat_t               mat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[MAT_LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cycz_r  <= smul30(trig[1].c, trig[2].c);
      cysz_r  <= smul30(trig[1].c, trig[2].s);
      sxsy_r  <= smul30(trig[0].s, trig[1].s);
      cxsz_r  <= smul30(trig[0].c, trig[2].s);
      cxcz_r  <= smul30(trig[0].c, trig[2].c);
      sxcy_r  <= smul30(trig[0].s, trig[1].c);
      cxsy_r  <= smul30(trig[0].c, trig[1].s);
      sxsz_r  <= smul30(trig[0].s, trig[2].s);
      sxcz_r  <= smul30(trig[0].s, trig[2].c);
      cxcy_r  <= smul30(trig[0].c, trig[1].c);
      sy_r    <= trig[1].s;
      sz_r    <= trig[2].s;
      cz_r    <= trig[2].c;
      // triple products, left to right
      a_r     <= smul30(sxsy_r, cz_r);
      b_r     <= smul30(sxsy_r, sz_r);
      c_r     <= smul30(cxsy_r, cz_r);
      d_r     <= smul30(cxsy_r, sz_r);
      cycz1_r <= cycz_r;
      cysz1_r <= cysz_r;
      cxsz1_r <= cxsz_r;
      cxcz1_r <= cxcz_r;
      sxcy1_r <= sxcy_r;
      sxsz1_r <= sxsz_r;
      sxcz1_r <= sxcz_r;
      cxcy1_r <= cxcy_r;
      sy1_r   <= sy_r;
      mat_r[0] <= 33'(cycz1_r);
      mat_r[1] <= 33'(cysz1_r);
      mat_r[2] <= -33'(sy1_r);
      mat_r[3] <= 33'(a_r) - 33'(cxsz1_r);
      mat_r[4] <= 33'(b_r) + 33'(cxcz1_r);
      mat_r[5] <= 33'(sxcy1_r);
      mat_r[6] <= 33'(c_r) + 33'(sxsz1_r);
      mat_r[7] <= 33'(d_r) - 33'(sxcz1_r);
      mat_r[8] <= 33'(cxcy1_r);
    end
  end

  assign out_vld = vld_r[MAT_LAT-1];
  assign mat     = mat_r;

endmodule
`default_nettype wire

FILE: rtl/core/trsmc_rowout.sv
// row sequencer: scales one row per cycle unless out_stall holds it, and drives the result register
`default_nettype none
module trsmc_rowout import trsmc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      mat_vld,
  input  wire mat_t      mat,
  input  wire side_t     side,
  output logic           take,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic               hold_vld_r;
  logic [1:0]         row_r;
  mat_t               hold_m_r;
  side_t              hold_side_r;
  logic               s1_vld_r;
  logic [1:0]         s1_row_r;
  logic signed [64:0] prod_r [3];
  logic signed [31:0] tr_r [3];
  logic               out_vld_r;
  out_item_t          out_r;

  logic               adv_t, issue, load;
  logic signed [32:0] elem_sel [3];
  logic signed [31:0] scale_sel;
  logic signed [31:0] col_nxt [3];
  logic signed [64:0] rnd;
  logic signed [34:0] shv;
  out_item_t          out_nxt;

  assign adv_t = !out_vld_r || !out_stall;
  assign issue = hold_vld_r && adv_t;
  assign take  = !hold_vld_r || (issue && row_r == ROW_LAST);
  assign load  = mat_vld && take;

  always_comb begin
    scale_sel = '0;
    for (int j = 0; j < 3; j++) elem_sel[j] = '0;
    unique case (row_r)
      2'd0: begin
        scale_sel = hold_side_r.scale_x;
        for (int j = 0; j < 3; j++) elem_sel[j] = hold_m_r[j];
      end
      2'd1: begin
        scale_sel = hold_side_r.scale_y;
        for (int j = 0; j < 3; j++) elem_sel[j] = hold_m_r[3+j];
      end
      2'd2: begin
        scale_sel = hold_side_r.scale_z;
        for (int j = 0; j < 3; j++) elem_sel[j] = hold_m_r[6+j];
      end
      default: ;
    endcase
  end

  always_comb begin
    rnd = '0;
    shv = '0;
    for (int j = 0; j < 3; j++) begin
      rnd = prod_r[j] + 65'sd536870912;
      shv = rnd[64:30];
      priority if (s1_row_r == ROW_LAST) col_nxt[j] = tr_r[j];
      else if (shv > 35'sd2147483647)    col_nxt[j] = 32'sh7FFF_FFFF;
      else if (shv < -35'sd2147483648)   col_nxt[j] = 32'sh8000_0000;
      else                               col_nxt[j] = shv[31:0];
    end
    out_nxt.col0      = col_nxt[0];
    out_nxt.col1      = col_nxt[1];
    out_nxt.col2      = col_nxt[2];
    out_nxt.col3      = (s1_row_r == ROW_LAST) ? (32'sd1 <<< FRAC_BITS) : '0;
    out_nxt.row_index = s1_row_r;
    out_nxt.last_row  = (s1_row_r == ROW_LAST);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      row_r      <= '0;
      s1_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (load) begin
        hold_vld_r <= 1'b1;
        row_r      <= '0;
      end else if (issue) begin
        row_r <= row_r + 2'd1;
        if (row_r == ROW_LAST) hold_vld_r <= 1'b0;
      end
      if (adv_t) begin
        s1_vld_r  <= issue;
        out_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold_m_r    <= mat;
      hold_side_r <= side;
    end
    if (adv_t) begin
      s1_row_r <= row_r;
      for (int j = 0; j < 3; j++) prod_r[j] <= 65'(elem_sel[j]) * 65'(scale_sel);
      tr_r[0]  <= hold_side_r.trans_x;
      tr_r[1]  <= hold_side_r.trans_y;
      tr_r[2]  <= hold_side_r.trans_z;
      out_r    <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

FILE: rtl/core/trs_matrix_compose_core.sv
// top level: translate-rotate-scale 4x4 matrix composer
//
// in_* takes one item (translation, Euler angles in degrees, scales, all
// signed Q16.16) per transfer; out_* returns the four matrix rows of it in
// order, row 0 first, each as one transfer, last_row set on row 3.
// Rotation is Rx*Ry*Rz in row-vector form; rows 0..2 are scaled, row 3
// carries the translation and 1.0 in col3.
// Row 0 passes the trig and matrix pipelines, the row hold register, the
// product register and the result register; rows 1..3 follow one per cycle
// when the receiver does not stall. Each item's four rows share the single
// result channel, which sets the item rate; the 20-stage angle and matrix
// pipeline takes an item in any cycle while the row sequencer has room.
// A stall on out_stall freezes the result register and then backs up the
// pipeline to in_stall; nothing is dropped or repeated.
// Reset clears all valid bits; no item is held across reset.
`default_nettype none
module trs_matrix_compose_core import trsmc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic             adv, take;
  logic             trig_vld, mat_vld;
  logic [2:0][31:0] angles;
  sc_t [2:0]        trig;
  mat_t             mat;
  side_t            side_r [SIDE_LAT];
  side_t            side_nxt;

  assign adv      = !mat_vld || take;
  assign in_stall = !adv;
  assign angles   = {in_data.angle_z, in_data.angle_y, in_data.angle_x};

  always_comb begin
    side_nxt.trans_x = in_data.trans_x;
    side_nxt.trans_y = in_data.trans_y;
    side_nxt.trans_z = in_data.trans_z;
    side_nxt.scale_x = in_data.scale_x;
    side_nxt.scale_y = in_data.scale_y;
    side_nxt.scale_z = in_data.scale_z;
  end

  // translation and scales ride alongside the trig and matrix stages
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side_nxt;
      for (int i = 1; i < SIDE_LAT; i++) side_r[i] <= side_r[i-1];
    end
  end

  trsmc_trig #(.FRAC_BITS(FRAC_BITS)) u_trig (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (in_valid && !in_stall),
    .angles  (angles),
    .out_vld (trig_vld),
    .trig    (trig)
  );

  trsmc_mat u_mat (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (trig_vld),
    .trig    (trig),
    .out_vld (mat_vld),
    .mat     (mat)
  );

  trsmc_rowout #(.FRAC_BITS(FRAC_BITS)) u_rowout (
    .clk       (clk),
    .rst_n     (rst_n),
    .mat_vld   (mat_vld),
    .mat       (mat),
    .side      (side_r[SIDE_LAT-1]),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_row == (out_data.row_index == ROW_LAST)))
    else $error("last_row does not match row_index");
  a_col3: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.row_index != ROW_LAST) |-> (out_data.col3 == '0))
    else $error("col3 nonzero on a rotation row");
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> mat_vld)
    else $error("input stalled with no matrix waiting");
`endif

endmodule
`default_nettype wire

FILE: bench/trs_matrix_compose_core_test.sv
// testbench for the matrix composer: random and directed items checked row by row
`default_nettype none
module trs_matrix_compose_core_test;
  import trsmc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;

  trs_matrix_compose_core #(.FRAC_BITS(FRAC)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  out_item_t expected_rows[$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_off = 1'b0;
  int quiet_cycles = 0;

  // round half up on a signed 64-bit product, back to q2.30
  function automatic longint shr30(longint v);
    if (v >= 0) return (v + (64'sd1 <<< 29)) >>> 30;
    return -(((-v) + (64'sd1 <<< 29) - 1) >>> 30);
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return shr30(a * b);
  endfunction

  function automatic longint uq30_mul(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic void deg_sin_cos(logic signed [31:0] ang, output longint sn,
                                      output longint cs);
    longint full, eighth, r, oct, rem, x, x2, t, s0, c0, one;
    full = 64'sd360 <<< FRAC;
    eighth = 64'sd45 <<< FRAC;
    one = 64'sd1 <<< 30;
    r = longint'(ang) % full;
    if (r < 0) r += full;
    oct = r / eighth;
    rem = r - oct * eighth;
    if (oct[0]) rem = eighth - rem;
    x = (rem * 64'sd3373259426 + (64'sd90 <<< FRAC)) / (64'sd180 <<< FRAC);
    x2 = uq30_mul(x, x);
    t = one - x2 / 72;
    t = one - uq30_mul(x2, t) / 42;
    t = one - uq30_mul(x2, t) / 20;
    t = one - uq30_mul(x2, t) / 6;
    s0 = uq30_mul(x, t);
    t = one - x2 / 56;
    t = one - uq30_mul(x2, t) / 30;
    t = one - uq30_mul(x2, t) / 12;
    c0 = one - uq30_mul(x2, t) / 2;
    case (oct[2:0])
      3'd0: begin sn = s0; cs = c0; end
      3'd1: begin sn = c0; cs = s0; end
      3'd2: begin sn = c0; cs = -s0; end
      3'd3: begin sn = s0; cs = -c0; end
      3'd4: begin sn = -s0; cs = -c0; end
      3'd5: begin sn = -c0; cs = -s0; end
      3'd6: begin sn = -c0; cs = s0; end
      default: begin sn = -s0; cs = c0; end
    endcase
  endfunction

  function automatic logic signed [31:0] scaled(longint e, logic signed [31:0] s);
    longint v;
    v = shr30(e * longint'(s));
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic void predict_matrix_rows(in_item_t it);
    longint sx, cx, sy, cy, sz, cz, p;
    longint m[3][3];
    logic signed [31:0] sc[3];
    out_item_t row;
    deg_sin_cos(it.angle_x, sx, cx);
    deg_sin_cos(it.angle_y, sy, cy);
    deg_sin_cos(it.angle_z, sz, cz);
    m[0][0] = q30_mul(cy, cz);
    m[0][1] = q30_mul(cy, sz);
    m[0][2] = -sy;
    p = q30_mul(sx, sy);
    m[1][0] = q30_mul(p, cz) - q30_mul(cx, sz);
    m[1][1] = q30_mul(p, sz) + q30_mul(cx, cz);
    m[1][2] = q30_mul(sx, cy);
    p = q30_mul(cx, sy);
    m[2][0] = q30_mul(p, cz) + q30_mul(sx, sz);
    m[2][1] = q30_mul(p, sz) - q30_mul(sx, cz);
    m[2][2] = q30_mul(cx, cy);
    sc[0] = it.scale_x;
    sc[1] = it.scale_y;
    sc[2] = it.scale_z;
    for (int r = 0; r < 3; r++) begin
      row.col0 = scaled(m[r][0], sc[r]);
      row.col1 = scaled(m[r][1], sc[r]);
      row.col2 = scaled(m[r][2], sc[r]);
      row.col3 = '0;
      row.row_index = 2'(r);
      row.last_row = 1'b0;
      expected_rows = {expected_rows, row};
    end
    row.col0 = it.trans_x;
    row.col1 = it.trans_y;
    row.col2 = it.trans_z;
    row.col3 = 32'sd1 <<< FRAC;
    row.row_index = ROW_LAST;
    row.last_row = 1'b1;
    expected_rows = {expected_rows, row};
  endfunction

  // receiver side: stall pattern, row checks and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_off || ($urandom_range(99) < stall_pct);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (expected_rows.size() == 0) begin
          $error("unexpected row transfer row_index=%0d", out_data.row_index);
          errors++;
        end else begin
          out_item_t e;
          e = expected_rows.pop_front();
          if (out_data.col0 !== e.col0) begin
            $error("col0 expected %0d actual %0d", e.col0, out_data.col0); errors++;
          end
          if (out_data.col1 !== e.col1) begin
            $error("col1 expected %0d actual %0d", e.col1, out_data.col1); errors++;
          end
          if (out_data.col2 !== e.col2) begin
            $error("col2 expected %0d actual %0d", e.col2, out_data.col2); errors++;
          end
          if (out_data.col3 !== e.col3) begin
            $error("col3 expected %0d actual %0d", e.col3, out_data.col3); errors++;
          end
          if (out_data.row_index !== e.row_index) begin
            $error("row_index expected %0d actual %0d", e.row_index, out_data.row_index);
            errors++;
          end
          if (out_data.last_row !== e.last_row) begin
            $error("last_row expected %0d actual %0d", e.last_row, out_data.last_row);
            errors++;
          end
        end
      end
    end
  end

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_matrix_rows(it);
  endtask

  // drop valid after the last transfer of a sequence
  task automatic end_items();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_item_t make_item(logic signed [31:0] ax, logic signed [31:0] ay,
                                         logic signed [31:0] az, logic signed [31:0] s);
    in_item_t it;
    it.trans_x = $urandom;
    it.trans_y = $urandom;
    it.trans_z = $urandom;
    it.angle_x = ax;
    it.angle_y = ay;
    it.angle_z = az;
    it.scale_x = s;
    it.scale_y = s;
    it.scale_z = s;
    return it;
  endfunction

  function automatic logic signed [31:0] rand_angle();
    case ($urandom_range(3))
      0: return $urandom;
      1: return ($urandom_range(16) * 45 - 360) <<< FRAC;
      default: return $signed($urandom_range(32'd47185920)) - 32'sd23592960;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_scale();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
      default: return $signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000;
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it = make_item(rand_angle(), rand_angle(), rand_angle(), 32'sh0001_0000);
    it.scale_x = rand_scale();
    it.scale_y = rand_scale();
    it.scale_z = rand_scale();
    return it;
  endfunction

  task automatic wait_drained();
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic test_directed();
    in_item_t it;
    send_item(make_item(0, 0, 0, 32'sh0001_0000));
    for (int k = 0; k < 8; k++)
      send_item(make_item((45 * k + 10) <<< FRAC, (45 * k) <<< FRAC,
                          (45 * k + 30) <<< FRAC, 32'sh0001_0000));
    // negative and wrapped angles
    send_item(make_item(-(30 <<< FRAC), -(400 <<< FRAC), 720 <<< FRAC, 32'sh0002_8000));
    send_item(make_item(32'sh8000_0000, 32'sh7fff_ffff, -1, 32'sh0001_0000));
    send_item(make_item(360 <<< FRAC, (360 <<< FRAC) - 1, 1, 32'sh0001_0000));
    // saturation both ways
    send_item(make_item(0, 0, 0, 32'sh7fff_ffff));
    send_item(make_item(0, 0, 0, 32'sh8000_0000));
    send_item(make_item(45 <<< FRAC, 45 <<< FRAC, 45 <<< FRAC, 32'sh8000_0000));
    send_item(make_item(135 <<< FRAC, 20 <<< FRAC, 200 <<< FRAC, 32'sh7fff_ffff));
    send_item(make_item(0, 0, 0, 0));
    send_item(make_item(0, 0, 0, -1));
    it = make_item(10 <<< FRAC, 0, 0, 32'sh0001_0000);
    it.trans_x = 32'sh7fff_ffff; it.trans_y = 32'sh8000_0000; it.trans_z = 0;
    send_item(it);
    it.trans_x = 32'sh8000_0000; it.trans_y = 32'sh7fff_ffff; it.trans_z = -1;
    send_item(it);
    end_items();
  endtask

  task automatic test_random(int count, int idle, int stall);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) send_item(rand_item());
    end_items();
    idle_pct = 0;
    stall_pct = 0;
  endtask

  // receiver holds off long while items keep arriving
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 30; i++) send_item(rand_item());
        end_items();
      end
    join
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(60, 0, 0);
    test_random(50, 80, 0);
    test_random(50, 0, 80);
    test_random(50, 11, 11);
    test_backpressure();
    wait_drained();
    if (errors == 0 && expected_rows.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/core/trsmc_pkg.sv
rtl/core/trsmc_trig.sv
rtl/core/trsmc_mat.sv
rtl/core/trsmc_rowout.sv
rtl/core/trs_matrix_compose_core.sv
bench/trs_matrix_compose_core_test.sv
